### design/ttlw_pkg.sv
`default_nettype none

package ttlw_pkg;

    // Payload and configuration widths
    localparam int LATCH_WORD_W = 24;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int BIT_POS_W    = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LE_SETUP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_TO_LE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LE_PULSE  = 3'd4;

    // Configuration reset values, in samples
    localparam logic [CFG_W-1:0] RST_LE_SETUP  = 8'd2;
    localparam logic [CFG_W-1:0] RST_CLK_LOW   = 8'd5;
    localparam logic [CFG_W-1:0] RST_CLK_HIGH  = 8'd5;
    localparam logic [CFG_W-1:0] RST_CLK_TO_LE = 8'd2;
    localparam logic [CFG_W-1:0] RST_LE_PULSE  = 8'd4;

    typedef struct packed {
        logic [CFG_W-1:0] le_setup;
        logic [CFG_W-1:0] clk_low;
        logic [CFG_W-1:0] clk_high;
        logic [CFG_W-1:0] clk_to_le;
        logic [CFG_W-1:0] le_pulse;
    } t_cfg;

endpackage

`default_nettype wire

### design/ttlw_in_if.sv
`default_nettype none

interface ttlw_in_if import ttlw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    start_req;
    logic [LATCH_WORD_W-1:0] latch_word;

    modport source (output valid, output start_req, output latch_word, input ready);
    modport sink   (input valid, input start_req, input latch_word, output ready);
endinterface

`default_nettype wire

### design/ttlw_out_if.sv
`default_nettype none

interface ttlw_out_if;
    logic valid;
    logic ready;
    logic serial_clock;
    logic serial_data;
    logic latch_enable;
    logic busy_res;
    logic done_res;

    modport source (output valid, output serial_clock, output serial_data,
                    output latch_enable, output busy_res, output done_res, input ready);
    modport sink   (input valid, input serial_clock, input serial_data,
                    input latch_enable, input busy_res, input done_res, output ready);
endinterface

`default_nettype wire

### design/timed_three_wire_latch_writer_top.sv
// A request's sample appears on o_res in the cycle after it is accepted.
// Throughput: one request per cycle; the phase sequencer advances once per request
// and the single output register passes a new sample every cycle while o_res.ready is high.
// Reset (i_rst_n low, synchronous): sequencer idle, pins low, output empty,
// configuration back to its default sample counts.
`default_nettype none

module timed_three_wire_latch_writer_top
    import ttlw_pkg::*;
#(
    parameter int WORD_BITS = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    ttlw_in_if.sink             i_req,
    ttlw_out_if.source          o_res,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_CLK_TO_LE,
        PH_LE_PULSE
    } t_phase;

    typedef struct packed {
        t_phase               ph;
        logic [BIT_POS_W-1:0] bp;
        logic                 moved;
    } t_pos;

    localparam logic [BIT_POS_W-1:0] BIT_TOP = BIT_POS_W'(WORD_BITS - 1);

    // Length of a phase in samples
    function automatic logic [CFG_W-1:0] phase_len(t_phase ph, t_cfg c);
        logic [CFG_W-1:0] len;
        case (ph)
            PH_SETUP:     len = c.le_setup;
            PH_BIT_LOW:   len = c.clk_low;
            PH_BIT_HIGH:  len = c.clk_high;
            PH_CLK_TO_LE: len = c.clk_to_le;
            PH_LE_PULSE:  len = c.le_pulse;
            default:      len = '0;
        endcase
        return len;
    endfunction

    // Leave a used-up phase and skip all following empty phases in one go
    function automatic t_pos settle(t_phase ph, logic [BIT_POS_W-1:0] bp,
                                    logic [CFG_W-1:0] cnt, t_cfg c);
        t_pos   r;
        t_phase tail;
        logic   zl;
        logic   zh;
        r.ph    = ph;
        r.bp    = bp;
        r.moved = 1'b0;
        zl = (c.clk_low == '0);
        zh = (c.clk_high == '0);
        // first non-empty phase after the bit loop
        if (c.clk_to_le != '0) begin
            tail = PH_CLK_TO_LE;
        end else if (c.le_pulse != '0) begin
            tail = PH_LE_PULSE;
        end else begin
            tail = PH_IDLE;
        end
        if (ph != PH_IDLE && cnt >= phase_len(ph, c)) begin
            r.moved = 1'b1;
            case (ph)
                PH_SETUP: begin
                    r.bp = BIT_TOP;
                    if (!zl) begin
                        r.ph = PH_BIT_LOW;
                    end else if (!zh) begin
                        r.ph = PH_BIT_HIGH;
                    end else begin
                        r.ph = tail;
                    end
                end
                PH_BIT_LOW: begin
                    if (!zh) begin
                        r.ph = PH_BIT_HIGH;
                    end else if (bp != '0 && !zl) begin
                        r.ph = PH_BIT_LOW;
                        r.bp = bp - 1'b1;
                    end else begin
                        r.ph = tail;
                    end
                end
                PH_BIT_HIGH: begin
                    if (bp != '0 && !zl) begin
                        r.ph = PH_BIT_LOW;
                        r.bp = bp - 1'b1;
                    end else if (bp != '0 && !zh) begin
                        r.ph = PH_BIT_HIGH;
                        r.bp = bp - 1'b1;
                    end else begin
                        r.ph = tail;
                    end
                end
                PH_CLK_TO_LE: begin
                    r.ph = (c.le_pulse != '0) ? PH_LE_PULSE : PH_IDLE;
                end
                default: begin
                    r.ph = PH_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    // State
    t_cfg                    r_cfg;
    t_phase                  r_phase,   n_phase;
    logic [BIT_POS_W-1:0]    r_bit_pos, n_bit_pos;
    logic [CFG_W-1:0]        r_count,   n_count;
    logic [LATCH_WORD_W-1:0] r_word,    n_word;
    logic [2:0]              r_pins,    n_pins;   // {le, data, clk}
    logic                    r_res_valid;
    logic                    r_busy,    n_busy;
    logic                    r_done,    n_done;

    logic                    req_acc;
    logic                    active;
    t_pos                    s0;
    t_pos                    s1;
    logic [CFG_W-1:0]        cnt0;
    logic [CFG_W-1:0]        cnt1;
    logic                    data_bit;

    // Accept while the output slot is free or being drained
    assign i_req.ready = !r_res_valid || o_res.ready;
    assign req_acc     = i_req.valid && i_req.ready;

    // One sample tick
    always_comb begin
        active    = (r_phase != PH_IDLE) || i_req.start_req;
        n_word    = r_word;
        n_pins    = r_pins;
        n_busy    = 1'b0;
        data_bit  = 1'b0;
        cnt1      = '0;
        s1        = '0;
        if (r_phase == PH_IDLE) begin
            if (i_req.start_req) begin
                n_word = i_req.latch_word;
                s0     = settle(PH_SETUP, '0, '0, r_cfg);
            end else begin
                s0 = '{ph: r_phase, bp: r_bit_pos, moved: 1'b0};
            end
        end else begin
            s0 = settle(r_phase, r_bit_pos, r_count, r_cfg);
        end
        cnt0   = s0.moved ? '0 : r_count;
        n_done = active && (s0.ph == PH_IDLE);
        n_phase   = s0.ph;
        n_bit_pos = s0.bp;
        n_count   = cnt0;

        if (s0.ph != PH_IDLE) begin
            if (s0.bp < BIT_POS_W'(LATCH_WORD_W)) begin
                data_bit = n_word[s0.bp];
            end
            case (s0.ph)
                PH_BIT_LOW:  n_pins = {1'b0, data_bit, 1'b0};
                PH_BIT_HIGH: n_pins = {1'b0, data_bit, 1'b1};
                PH_LE_PULSE: n_pins = 3'b100;
                default:     n_pins = 3'b000;
            endcase
            n_busy    = 1'b1;
            cnt1      = cnt0 + 1'b1;
            s1        = settle(s0.ph, s0.bp, cnt1, r_cfg);
            n_phase   = s1.ph;
            n_bit_pos = s1.bp;
            n_count   = s1.moved ? '0 : cnt1;
            n_done    = (s1.ph == PH_IDLE);
        end
    end

    // Sequencer state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_pos   <= '0;
            r_count     <= '0;
            r_word      <= '0;
            r_pins      <= '0;
            r_res_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_cfg       <= '{le_setup: RST_LE_SETUP, clk_low: RST_CLK_LOW,
                             clk_high: RST_CLK_HIGH, clk_to_le: RST_CLK_TO_LE,
                             le_pulse: RST_LE_PULSE};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LE_SETUP:  r_cfg.le_setup  <= i_cfg_data;
                    CFG_CLK_LOW:   r_cfg.clk_low   <= i_cfg_data;
                    CFG_CLK_HIGH:  r_cfg.clk_high  <= i_cfg_data;
                    CFG_CLK_TO_LE: r_cfg.clk_to_le <= i_cfg_data;
                    CFG_LE_PULSE:  r_cfg.le_pulse  <= i_cfg_data;
                    default:       ;
                endcase
            end
            if (req_acc) begin
                r_phase   <= n_phase;
                r_bit_pos <= n_bit_pos;
                r_count   <= n_count;
                r_word    <= n_word;
                r_pins    <= n_pins;
                r_busy    <= n_busy;
                r_done    <= n_done;
            end
            if (req_acc) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.serial_clock = r_pins[0];
    assign o_res.serial_data  = r_pins[1];
    assign o_res.latch_enable = r_pins[2];
    assign o_res.busy_res     = r_busy;
    assign o_res.done_res     = r_done;

    // Every accepted request yields a sample in the next cycle
    a_req_gives_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> r_res_valid)
        else $error("accepted request produced no result");

    // A finished transfer leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && n_done) |=> (r_phase == PH_IDLE))
        else $error("done reported but sequencer not idle");

    // A tick with neither busy nor done never leaves idle
    a_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && !n_busy && !n_done) |=> (r_phase == PH_IDLE))
        else $error("sequencer left idle without emitting a sample");

    // Bit position stays within the word during the bit loop
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BIT_LOW || r_phase == PH_BIT_HIGH) |-> (r_bit_pos <= BIT_TOP))
        else $error("bit position out of range");

endmodule

`default_nettype wire
